@@ rtl/pica_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_pkg
// Shared types and constants for the PI controller with integrator clamping.
// ----------------------------------------------------------------------------
package pica_pkg;

  localparam int Q_W       = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 15;
  localparam int DIV_BITS  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER     = 2'd3;

  localparam logic signed [Q_W-1:0] PROP_GAIN_RST     = 32'sd65536;
  localparam logic signed [Q_W-1:0] INTEGRAL_GAIN_RST = 32'sd0;
  localparam logic signed [Q_W-1:0] OUT_UPPER_RST     = 32'sd26214400;
  localparam logic signed [Q_W-1:0] OUT_LOWER_RST     = -32'sd26214400;

  localparam logic [DIV_W-1:0] INC_DIVISOR = 15'd20000;
  localparam logic [63:0]      LIMIT_BASE  = 64'd400;

  localparam logic SEL_KP = 1'b0;
  localparam logic SEL_KI = 1'b1;

  typedef struct packed {
    logic ld_err;
    logic mul_en;
    logic mul_sel;
    logic prop_en;
    logic div_ld;
    logic div_step;
    logic acc_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/pica_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_ctrl
// Sequencer: accepts a sample, steps the datapath, commits the result.
// ----------------------------------------------------------------------------
module pica_ctrl
  import pica_pkg::*;
#(
  parameter int DIV_STEPS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULP  = 3'd1;
  localparam logic [2:0] S_PROP  = 3'd2;
  localparam logic [2:0] S_DIVLD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_err = 1'b1;
          state_nxt  = S_MULP;
        end
      end
      S_MULP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_KP;
        state_nxt   = S_PROP;
      end
      S_PROP: begin
        cmd.prop_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_KI;
        state_nxt   = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/pica_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_datapath
// Gain registers, shared multiplier, constant divider, clamps, integrator
// and output register.
// ----------------------------------------------------------------------------
module pica_datapath
  import pica_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int DIV_STEPS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [Q_W-1:0]       cfg_wdata,
  input  logic [2*Q_W-1:0]     in_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2*Q_W-1:0]     out_data
);

  localparam int NUM_W = 63 - FRAC_BITS;
  localparam int NP    = DIV_BITS * DIV_STEPS;
  localparam int ACC_W = (50 - FRAC_BITS > 35) ? (50 - FRAC_BITS) : 35;
  localparam logic signed [33:0] LIM400 =
    ((LIMIT_BASE << FRAC_BITS) > 64'd2147483647) ? 34'sh7FFFFFFF :
    34'((LIMIT_BASE << FRAC_BITS));

  logic signed [Q_W-1:0]   kp_r, ki_r, upper_r, lower_r;
  logic signed [Q_W-1:0]   err_r, prop_r, integ_r, integ_new_r;
  logic signed [63:0]      prod_r;
  logic signed [33:0]      hi_r, lo_r;
  logic                    neg_r;
  logic [NP-1:0]           num_r;
  logic [DIV_W-1:0]        rem_r;
  logic                    out_valid_r;
  logic [2*Q_W-1:0]        out_data_r;

  logic signed [Q_W-1:0]   sp, fb, mul_b, prop_sat, prop_clamp;
  logic signed [63:0]      prod_sh;
  logic [63:0]             mag;
  logic [NP-1:0]           num_nxt;
  logic [DIV_W-1:0]        rem_nxt;
  logic [DIV_W:0]          rem_t;
  logic signed [ACC_W-1:0] inc, acc;
  logic signed [Q_W-1:0]   drive;

  assign sp    = in_data[Q_W-1:0];
  assign fb    = in_data[2*Q_W-1:Q_W];
  assign mul_b = (cmd.mul_sel == SEL_KI) ? ki_r : kp_r;

  always_comb begin
    prod_sh    = prod_r >>> FRAC_BITS;
    prop_sat   = sat32(prod_sh);
    prop_clamp = prop_sat;
    if (prop_clamp >= upper_r) begin
      prop_clamp = upper_r;
    end
    if (prop_clamp <= lower_r) begin
      prop_clamp = lower_r;
    end
  end

  assign mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_t   = {rem_nxt, num_nxt[NP-1]};
      num_nxt = {num_nxt[NP-2:0], 1'b0};
      if (rem_t >= {1'b0, INC_DIVISOR}) begin
        rem_t      = rem_t - {1'b0, INC_DIVISOR};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = rem_t[DIV_W-1:0];
    end
  end

  always_comb begin
    inc = neg_r ? -$signed(ACC_W'(num_r)) : $signed(ACC_W'(num_r));
    acc = ACC_W'(integ_r) + inc;
    if (acc >= ACC_W'(hi_r)) begin
      acc = ACC_W'(hi_r);
    end
    if (acc <= ACC_W'(lo_r)) begin
      acc = ACC_W'(lo_r);
    end
  end

  assign drive = sat32(64'(integ_new_r) + 64'(prop_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= PROP_GAIN_RST;
      ki_r    <= INTEGRAL_GAIN_RST;
      upper_r <= OUT_UPPER_RST;
      lower_r <= OUT_LOWER_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_PROP_GAIN:     kp_r    <= cfg_wdata;
        REG_INTEGRAL_GAIN: ki_r    <= cfg_wdata;
        REG_OUT_UPPER:     upper_r <= cfg_wdata;
        REG_OUT_LOWER:     lower_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_err) begin
      err_r <= sat32(64'(sp) - 64'(fb));
    end
    if (cmd.mul_en) begin
      prod_r <= err_r * mul_b;
    end
    if (cmd.prop_en) begin
      prop_r <= prop_clamp;
    end
    if (cmd.div_ld) begin
      neg_r <= prod_r[63];
      num_r <= NP'(mag[62:FRAC_BITS]);
      rem_r <= '0;
      if (!prop_r[Q_W-1]) begin
        hi_r <= 34'(upper_r) - 34'(prop_r);
        lo_r <= -LIM400;
      end else begin
        hi_r <= LIM400;
        lo_r <= 34'(lower_r) - 34'(prop_r);
      end
    end
    if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.acc_en) begin
      integ_new_r <= sat32(64'(acc));
    end
    if (cmd.commit) begin
      out_data_r <= {integ_new_r, drive};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        integ_r     <= integ_new_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

@@ rtl/pi_controller_antiwindup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_controller_antiwindup
// PI controller with clamped proportional term and integrator headroom.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one control sample per transfer, setpoint and feedback, signed
//           fixed point with FRAC_BITS fraction bits.
//   out_* : one result per sample, drive and the updated integrator.
//   cfg_* : write gains and output limits while the block is idle.
// Each sample transfer loads the error; the proportional and integral
//   products follow on the shared multiplier, then the divider is loaded and
//   steps through the integral increment, resolving four quotient bits a
//   cycle; the integrator is updated and the result waits for a free output
//   register. A new sample is taken once the previous result sits in the
//   output register.
// Reset: gains and limits return to their defaults, the integrator clears,
//   no result is pending.
// Stall: a held result stays in the output register; the next sample is
//   still accepted and processed, then waits until the register frees.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup
  import pica_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [Q_W-1:0]       cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*Q_W-1:0]     in_tdata,   // setpoint, feedback
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*Q_W-1:0]     out_tdata   // drive, integrator_now
);

  localparam int DIV_STEPS = (63 - FRAC_BITS + DIV_BITS - 1) / DIV_BITS;

  cmd_t cmd;
  sts_t sts;

  pica_ctrl #(
    .DIV_STEPS(DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pica_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .DIV_STEPS(DIV_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ verif/pi_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_result_checker
// Watches the sample, result and register ports of the PI controller, keeps
// its own copy of gains, limits and integrator, predicts drive and
// integrator_now for every sample transfer and compares each result transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pi_result_checker
  import pica_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [Q_W-1:0]       cfg_wdata,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [2*Q_W-1:0]     in_tdata,   // setpoint, feedback
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [2*Q_W-1:0]     out_tdata,  // drive, integrator_now
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic signed [Q_W-1:0] drive;
    logic signed [Q_W-1:0] integ;
  } pi_result_t;

  longint     kp;
  longint     ki;
  longint     upper_lim;
  longint     lower_lim;
  longint     integ_acc;
  pi_result_t drive_q[$];
  pi_result_t head_r;
  logic signed [Q_W-1:0] got_drive;
  logic signed [Q_W-1:0] got_integ;
  int         mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint clamp_s32(input longint v);
    longint r;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic pi_result_t control_step(input logic signed [Q_W-1:0] sp,
                                              input logic signed [Q_W-1:0] fb);
    longint     err;
    longint     prop;
    longint     lim;
    longint     hi;
    longint     lo;
    longint     inc;
    longint     acc;
    pi_result_t r;
    err  = clamp_s32(longint'(sp) - longint'(fb));
    prop = clamp_s32((err * kp) >>> FRAC_BITS);
    lim  = clamp_s32(longint'(400) <<< FRAC_BITS);
    if (prop >= upper_lim) prop = upper_lim;
    if (prop <= lower_lim) prop = lower_lim;
    if (prop >= 0) begin
      hi = upper_lim - prop;
      lo = -lim;
    end else begin
      lo = lower_lim - prop;
      hi = lim;
    end
    inc = (err * ki) / (longint'(20000) <<< FRAC_BITS);
    acc = integ_acc + inc;
    if (acc >= hi) acc = hi;
    if (acc <= lo) acc = lo;
    integ_acc = clamp_s32(acc);
    r.drive = Q_W'(clamp_s32(integ_acc + prop));
    r.integ = Q_W'(integ_acc);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      kp        = longint'(PROP_GAIN_RST);
      ki        = longint'(INTEGRAL_GAIN_RST);
      upper_lim = longint'(OUT_UPPER_RST);
      lower_lim = longint'(OUT_LOWER_RST);
      integ_acc = 0;
      drive_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_drive = out_tdata[Q_W-1:0];
        got_integ = out_tdata[2*Q_W-1:Q_W];
        if (drive_q.size() == 0) begin
          $error("result transfer with no sample outstanding: drive %0d, integrator_now %0d",
                 got_drive, got_integ);
          mismatches++;
        end else begin
          head_r = drive_q.pop_front();
          if (got_drive !== head_r.drive) begin
            $error("drive: expected %0d, actual %0d", head_r.drive, got_drive);
            mismatches++;
          end
          if (got_integ !== head_r.integ) begin
            $error("integrator_now: expected %0d, actual %0d", head_r.integ, got_integ);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        drive_q.push_back(control_step(in_tdata[Q_W-1:0], in_tdata[2*Q_W-1:Q_W]));
      end
      if (cfg_wen) begin
        case (cfg_addr)
          REG_PROP_GAIN:     kp        = longint'($signed(cfg_wdata));
          REG_INTEGRAL_GAIN: ki        = longint'($signed(cfg_wdata));
          REG_OUT_UPPER:     upper_lim = longint'($signed(cfg_wdata));
          REG_OUT_LOWER:     lower_lim = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= drive_q.size();
  end

endmodule

@@ verif/tb_pi_controller_antiwindup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pi_controller_antiwindup
// Drives control samples into the PI controller under directed and random
// gain and limit settings, with random idling on both stream sides and one
// long output hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_pi_controller_antiwindup;
  import pica_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int LATENCY        = 6 + (63 - FRAC_BITS + 3) / 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SEG_ITEMS      = 150;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [Q_W-1:0]       cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [2*Q_W-1:0]     in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [2*Q_W-1:0]     out_tdata;

  int fail_count;
  int results_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int idle_cycles = 0;

  pi_controller_antiwindup #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pi_result_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [Q_W-1:0] sp, input logic [Q_W-1:0] fb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fb, sp};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic apply_config(input logic [Q_W-1:0] kp, input logic [Q_W-1:0] ki,
                              input logic [Q_W-1:0] hi, input logic [Q_W-1:0] lo);
    cfg_wen   <= 1'b1;
    cfg_addr  <= REG_PROP_GAIN;
    cfg_wdata <= kp;
    @(posedge clk);
    cfg_addr  <= REG_INTEGRAL_GAIN;
    cfg_wdata <= ki;
    @(posedge clk);
    cfg_addr  <= REG_OUT_UPPER;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr  <= REG_OUT_LOWER;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every outstanding result, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [Q_W-1:0] rand_sample();
    logic [Q_W-1:0] v;
    case ($urandom_range(15))
      0:       v = Q_MAX;
      1:       v = Q_MIN;
      2, 3, 4: v = $urandom;
      default: v = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
    return v;
  endfunction

  function automatic logic [Q_W-1:0] rand_limit();
    logic [Q_W-1:0] v;
    case ($urandom_range(7))
      0:       v = Q_MAX;
      1:       v = Q_MIN;
      2:       v = '0;
      3:       v = $urandom;
      default: v = (int'($urandom_range(0, 2000)) - 1000) * 65536;
    endcase
    return v;
  endfunction

  task automatic random_config();
    logic [Q_W-1:0] kp;
    logic [Q_W-1:0] ki;
    logic [Q_W-1:0] hi;
    logic [Q_W-1:0] lo;
    logic [Q_W-1:0] swap;
    case ($urandom_range(5))
      0:       kp = Q_MAX;
      1:       kp = Q_MIN;
      2:       kp = $urandom;
      default: kp = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
    case ($urandom_range(5))
      0:       ki = Q_MAX;
      1:       ki = Q_MIN;
      2:       ki = $urandom;
      default: ki = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
    hi = rand_limit();
    lo = rand_limit();
    if ($signed(hi) < $signed(lo) && $urandom_range(3) != 0) begin
      swap = hi;
      hi   = lo;
      lo   = swap;
    end
    apply_config(kp, ki, hi, lo);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: unit gain, no integral action
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, 32'h0000_0000);
    send_sample(Q_MIN, 32'h0000_0000);
    send_sample(32'h0001_0000, 32'h0000_0000);
    send_sample(32'hFFFF_0000, 32'h0000_0000);
    send_sample(32'h01F4_0000, 32'h0000_0000);
    settle();

    // full-scale gains and limits: integrator runs into both clamps
    apply_config(Q_MAX, Q_MAX, Q_MAX, Q_MIN);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MIN, Q_MAX);
    settle();

    // crossed output limits, which also cross the integrator headroom
    apply_config(32'h0001_0000, 32'h0100_0000, -32'sd65536000, 32'sd32768000);
    send_sample(32'h0010_0000, 32'h0000_0000);
    send_sample(32'hFFF0_0000, 32'h0000_0000);
    send_sample(Q_MAX, Q_MIN);
    settle();

    // most negative gains, zero-width output range
    apply_config(Q_MIN, Q_MIN, 32'h0000_0000, 32'h0000_0000);
    send_sample(32'h0123_4567, 32'hFEDC_BA98);
    send_sample(Q_MIN, Q_MAX);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        random_config();
        if (phase == 2 && seg == 0) hold_req = 1'b1;
        for (int n = 0; n < SEG_ITEMS; n++) begin
          send_sample(rand_sample(), rand_sample());
        end
        settle();
      end
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
